/* hw/rtl/dobs_pkg.sv */
// Package: constants and reciprocal table for the diode operating point solver.
`timescale 1ns / 1ps
package dobs_pkg;
    localparam int MUL_W = 32;
    localparam logic [31:0] KL_Q24  = 32'd936112526;
    localparam logic [31:0] CI_Q24  = 32'd2296178;
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [47:0] CUR_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] TOL_ONE = 32'h0100_0000;
    localparam logic [3:0]  TERMS   = 4'd12;

    // floor(2^32 / k), k = 2..12
    function automatic logic [31:0] recip(input logic [3:0] k);
        logic [31:0] r;
        begin
            case (k)
                4'd2:    r = 32'd2147483648;
                4'd3:    r = 32'd1431655765;
                4'd4:    r = 32'd1073741824;
                4'd5:    r = 32'd858993459;
                4'd6:    r = 32'd715827882;
                4'd7:    r = 32'd613566756;
                4'd8:    r = 32'd536870912;
                4'd9:    r = 32'd477218588;
                4'd10:   r = 32'd429496729;
                4'd11:   r = 32'd390451572;
                4'd12:   r = 32'd357913941;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage

/* hw/rtl/dobs_mul.sv */
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module dobs_mul
(
    input  logic                           clk,
    input  logic [dobs_pkg::MUL_W-1:0]     a,
    input  logic [dobs_pkg::MUL_W-1:0]     b,
    output logic [2*dobs_pkg::MUL_W-1:0]   p
);
    import dobs_pkg::*;

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule

/* hw/rtl/diode_operating_point_bisection_top.sv */
// Top level: diode operating point by bisection over one shared multiplier.
`timescale 1ns / 1ps
// Solves the series source/resistor/diode circuit for one request at a time.
// Every bisection step runs the stop test and then evaluates the diode
// current with a base-2 exponential. That evaluation is a setup (S_E0 to
// S_E2), a 12-term Horner series in which each of the first eleven terms
// passes S_H1 to S_H4 and the last term only S_H1 and S_H2, and one shift.
// A residual test (S_R1 to S_R3) follows, all through one 32x32 multiplier.
// A request takes at most MAX_STEPS steps and a closing current evaluation
// before its result is offered. A saturated exponential skips the Horner
// series. An invalid request goes straight to the output state. s_tready is
// low while a request is being solved or its result waits on the master
// side.
module diode_operating_point_bisection_top
#(
    parameter int MAX_STEPS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // source_voltage, resistance, tolerance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // diode_voltage[30:0], diode_current[78:31], zero pad
    output logic        m_tuser    // status
);
    import dobs_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(MAX_STEPS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_E0    = 4'd2;
    localparam logic [3:0] S_E1    = 4'd3;
    localparam logic [3:0] S_E2    = 4'd4;
    localparam logic [3:0] S_H1    = 4'd5;
    localparam logic [3:0] S_H2    = 4'd6;
    localparam logic [3:0] S_H3    = 4'd7;
    localparam logic [3:0] S_H4    = 4'd8;
    localparam logic [3:0] S_SHIFT = 4'd9;
    localparam logic [3:0] S_R1    = 4'd10;
    localparam logic [3:0] S_R2    = 4'd11;
    localparam logic [3:0] S_R3    = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]        state_reg;
    logic [31:0]       u0_reg, r_reg, eps_reg;
    logic [31:0]       lo_reg, hi_reg, last_reg, mid_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              final_reg;
    logic [16:0]       n_reg;
    logic [29:0]       t_reg;
    logic [31:0]       s_reg, q_reg, est_reg, lowh_reg;
    logic [3:0]        k_reg;
    logic [47:0]       cur_reg;
    logic [30:0]       volt_reg;
    logic              stat_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    dobs_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    logic [31:0] in_u0, in_r, in_eps;
    logic        in_bad;
    logic [32:0] mid_sum;
    logic [31:0] mid_new;
    logic [40:0] z_w;
    logic [31:0] rem_w;
    logic [5:0]  sh_w;
    logic [63:0] raw_w;
    logic [63:0] res_hi;
    logic [31:0] diff_w;

    assign in_u0   = s_tdata[31:0];
    assign in_r    = s_tdata[63:32];
    assign in_eps  = s_tdata[95:64];
    assign in_bad  = in_u0[31] | in_r[31] | in_eps[31] | (in_eps > TOL_ONE);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_new = mid_sum[32:1];
    assign z_w     = {1'b0, prod[63:24]} + {9'd0, CI_Q24};
    assign rem_w   = q_reg - prod[31:0];
    assign sh_w    = (n_reg >= 17'd30) ? 6'(n_reg - 17'd30) : 6'(17'd30 - n_reg);
    assign raw_w   = (n_reg >= 17'd30) ? ({32'd0, s_reg} << sh_w) : ({32'd0, s_reg} >> sh_w);
    assign res_hi  = prod + {32'd0, lowh_reg};
    assign diff_w  = u0_reg - mid_reg;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_E0:
            begin
                mul_a = mid_reg;
                mul_b = KL_Q24;
            end
            S_E1:
            begin
                mul_a = {8'd0, z_w[23:0]};
                mul_b = LN2_Q30;
            end
            S_H1:
            begin
                mul_a = {2'd0, t_reg};
                mul_b = s_reg;
            end
            S_H2:
            begin
                mul_a = prod[61:30];
                mul_b = recip(k_reg);
            end
            S_H3:
            begin
                mul_a = prod[63:32];
                mul_b = {28'd0, k_reg};
            end
            S_R1:
            begin
                mul_a = cur_reg[31:0];
                mul_b = r_reg;
            end
            S_R2:
            begin
                mul_a = {16'd0, cur_reg[47:32]};
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            u0_reg    <= 32'd0;
            r_reg     <= 32'd0;
            eps_reg   <= 32'd0;
            lo_reg    <= 32'd0;
            hi_reg    <= 32'd0;
            last_reg  <= 32'd0;
            mid_reg   <= 32'd0;
            steps_reg <= '0;
            final_reg <= 1'b0;
            n_reg     <= 17'd0;
            t_reg     <= 30'd0;
            s_reg     <= 32'd0;
            q_reg     <= 32'd0;
            est_reg   <= 32'd0;
            lowh_reg  <= 32'd0;
            k_reg     <= 4'd0;
            cur_reg   <= 48'd0;
            volt_reg  <= 31'd0;
            stat_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        u0_reg    <= in_u0;
                        r_reg     <= in_r;
                        eps_reg   <= in_eps;
                        lo_reg    <= 32'd0;
                        hi_reg    <= in_u0;
                        last_reg  <= 32'd0;
                        mid_reg   <= {1'b0, in_u0[31:1]};
                        steps_reg <= '0;
                        final_reg <= 1'b0;
                        if (in_bad)
                        begin
                            volt_reg  <= 31'd0;
                            cur_reg   <= 48'd0;
                            stat_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    state_reg <= S_E0;
                    if ((hi_reg - lo_reg) > eps_reg && steps_reg < STEP_LIM
                        && mid_new != last_reg)
                    begin
                        mid_reg <= mid_new;
                    end
                    else
                    begin
                        final_reg <= 1'b1;
                    end
                end
                S_E0:
                begin
                    state_reg <= S_E1;
                end
                S_E1:
                begin
                    n_reg <= z_w[40:24];
                    if (z_w[40:24] >= 17'd48)
                    begin
                        cur_reg   <= CUR_MAX;
                        state_reg <= S_R1;
                    end
                    else
                    begin
                        state_reg <= S_E2;
                    end
                end
                S_E2:
                begin
                    t_reg     <= prod[53:24];
                    s_reg     <= ONE_Q30;
                    k_reg     <= TERMS;
                    state_reg <= S_H1;
                end
                S_H1:
                begin
                    state_reg <= S_H2;
                end
                S_H2:
                begin
                    q_reg <= prod[61:30];
                    if (k_reg == 4'd1)
                    begin
                        s_reg     <= ONE_Q30 + prod[61:30];
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_H3;
                    end
                end
                S_H3:
                begin
                    est_reg   <= prod[63:32];
                    state_reg <= S_H4;
                end
                S_H4:
                begin
                    // reciprocal estimate is at most one short
                    if (rem_w >= {28'd0, k_reg})
                        s_reg <= ONE_Q30 + est_reg + 32'd1;
                    else
                        s_reg <= ONE_Q30 + est_reg;
                    k_reg     <= k_reg - 4'd1;
                    state_reg <= S_H1;
                end
                S_SHIFT:
                begin
                    if (raw_w > {16'd0, CUR_MAX})
                        cur_reg <= CUR_MAX - 48'd1;
                    else if (raw_w != 64'd0)
                        cur_reg <= raw_w[47:0] - 48'd1;
                    else
                        cur_reg <= 48'd0;
                    state_reg <= S_R1;
                end
                S_R1:
                begin
                    if (final_reg)
                    begin
                        volt_reg  <= mid_reg[30:0];
                        stat_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_R2;
                    end
                end
                S_R2:
                begin
                    lowh_reg  <= prod[63:32];
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    if (res_hi < {32'd0, diff_w})
                        lo_reg <= mid_reg;
                    else
                        hi_reg <= mid_reg;
                    last_reg  <= mid_reg;
                    steps_reg <= steps_reg + STEP_W'(1);
                    state_reg <= S_CHECK;
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, cur_reg, volt_reg};
    assign m_tuser  = stat_reg;
endmodule
